// ===== src/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants of the telemetry frame decoder.
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int unsigned POS_W = 5;

    localparam logic [POS_W-1:0] POS_MAGIC   = 5'd0;
    localparam logic [POS_W-1:0] POS_VERSION = 5'd1;
    localparam logic [POS_W-1:0] POS_TYPE    = 5'd2;
    localparam logic [POS_W-1:0] POS_FIELD0  = 5'd3;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 5'd20;   // first byte after CRC span
    localparam logic [POS_W-1:0] POS_CRC_HI  = 5'd21;   // last frame byte
    localparam logic [POS_W-1:0] POS_IDLE    = 5'd22;

    localparam int unsigned FIELD_COUNT = 17;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] FRAME_TYPE = 8'd1;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         flags;
        logic [15:0]        node_id;
        logic [15:0]        sequence_res;
        logic [31:0]        up_seconds;
        logic signed [15:0] asset_temp;
        logic signed [15:0] ambient_temp;
        logic [7:0]         confidence;
        logic [7:0]         device_state;
        logic [15:0]        batt_millivolts;
    } tdf_result_t;

    // Control flags from the frame tracker to the output stage.
    typedef struct packed {
        logic done;         // accepted byte closes a frame
        logic at_last;      // next byte is the last frame byte
    } tdf_ctl_t;

endpackage

// ===== src/tdf_ifaces.sv =====
// ----------------------------------------------------------------------------
// tdf_ifaces
// Valid/ready channels for frame bytes and decoded frame results.
// ----------------------------------------------------------------------------
interface tdf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tdf_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         flags;
    logic [15:0]        node_id;
    logic [15:0]        sequence_res;
    logic [31:0]        up_seconds;
    logic signed [15:0] asset_temp;
    logic signed [15:0] ambient_temp;
    logic [7:0]         confidence;
    logic [7:0]         device_state;
    logic [15:0]        batt_millivolts;

    modport source (
        output valid, output status, output flags, output node_id,
        output sequence_res, output up_seconds, output asset_temp, output ambient_temp,
        output confidence, output device_state, output batt_millivolts, input ready
    );
    modport sink (
        input valid, input status, input flags, input node_id,
        input sequence_res, input up_seconds, input asset_temp, input ambient_temp,
        input confidence, input device_state, input batt_millivolts, output ready
    );
endinterface

// ===== src/tdf_crc_byte.sv =====
// ----------------------------------------------------------------------------
// tdf_crc_byte
// One-byte CRC-16/CCITT-FALSE update, MSB first, unrolled XOR network.
// ----------------------------------------------------------------------------
module tdf_crc_byte (
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_upd
);
    import tdf_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_upd = c;
    end

endmodule

// ===== src/tdf_frame_ctl.sv =====
// ----------------------------------------------------------------------------
// tdf_frame_ctl
// Frame position tracking, header check, running CRC, field capture and result decode.
// ----------------------------------------------------------------------------
module tdf_frame_ctl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  frame_start,
    input  logic [7:0]            magic_byte,
    input  logic [7:0]            version_byte,
    output tdf_pkg::tdf_ctl_t     ctl,
    output tdf_pkg::tdf_result_t  result
);
    import tdf_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [15:0]      crc_reg, crc_next, crc_base, crc_upd;
    logic             hdr_bad_reg, hdr_bad_next, hdr_base;
    logic [7:0]       field_reg [FIELD_COUNT];
    logic [7:0]       crc_lo_reg;
    logic             active;
    logic [15:0]      rx_crc;
    logic [1:0]       status;

    assign pos_eff  = frame_start ? POS_MAGIC : pos_reg;
    assign active   = frame_start || (pos_reg != POS_IDLE);
    assign crc_base = frame_start ? CRC_INIT : crc_reg;
    assign hdr_base = frame_start ? 1'b0 : hdr_bad_reg;

    tdf_crc_byte u_crc (
        .crc     (crc_base),
        .data    (data_byte),
        .crc_upd (crc_upd)
    );

    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        hdr_bad_next = hdr_bad_reg;
        if (accept && active)
        begin
            crc_next     = (pos_eff < POS_CRC_LO) ? crc_upd : crc_base;
            hdr_bad_next = hdr_base
                | ((pos_eff == POS_MAGIC)   && (data_byte != magic_byte))
                | ((pos_eff == POS_VERSION) && (data_byte != version_byte))
                | ((pos_eff == POS_TYPE)    && (data_byte != FRAME_TYPE));
            pos_next     = (pos_eff == POS_CRC_HI) ? POS_IDLE : pos_eff + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_IDLE;
            crc_reg     <= CRC_INIT;
            hdr_bad_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            hdr_bad_reg <= hdr_bad_next;
        end
    end

    // Field bytes 3..19 shift in; after byte 19 entry 0 holds byte 3.
    always_ff @(posedge clk)
    begin
        if (accept && active && (pos_eff >= POS_FIELD0) && (pos_eff < POS_CRC_LO))
        begin
            for (int i = 0; i < FIELD_COUNT - 1; i++)
            begin
                field_reg[i] <= field_reg[i+1];
            end
            field_reg[FIELD_COUNT-1] <= data_byte;
        end
        if (accept && active && (pos_eff == POS_CRC_LO))
        begin
            crc_lo_reg <= data_byte;
        end
    end

    assign ctl.done    = accept && active && (pos_eff == POS_CRC_HI);
    assign ctl.at_last = (pos_reg == POS_CRC_HI);

    // At the last byte no start is seen, so crc_reg and hdr_bad_reg are final.
    assign rx_crc = {data_byte, crc_lo_reg};

    always_comb
    begin
        if (hdr_bad_reg)
        begin
            status = STATUS_BAD_HDR;
        end
        else if (rx_crc != crc_reg)
        begin
            status = STATUS_BAD_CRC;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_comb
    begin
        result = '0;
        result.status = status;
        if (status == STATUS_OK)
        begin
            result.flags           = field_reg[0];
            result.node_id         = {field_reg[2], field_reg[1]};
            result.sequence_res    = {field_reg[4], field_reg[3]};
            result.up_seconds      = {field_reg[8], field_reg[7], field_reg[6], field_reg[5]};
            result.asset_temp      = {field_reg[10], field_reg[9]};
            result.ambient_temp    = {field_reg[12], field_reg[11]};
            result.confidence      = field_reg[13];
            result.device_state    = field_reg[14];
            result.batt_millivolts = {field_reg[16], field_reg[15]};
        end
    end

endmodule

// ===== src/telemetry_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_decoder_core
// Checks and decodes fixed 22-byte telemetry frames with CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
//
//  Channel      Dir   Handshake     Moves
//  frame_bytes  in    valid/ready   one frame byte plus start flag per request
//  results      out   valid/ready   one decoded frame (status + fields)
//  cfg_*        in    write enable  magic_byte (index 0), version_byte (index 1)
//
//  One byte is taken per cycle unless held off; the CRC byte update is a single
//  XOR network. Results appear in the cycle after a frame's last byte is taken.
//  Reset (rst_n low) returns the tracker to idle and empties the result register.
//  A stalled result only holds off input when the next byte is a frame's last
//  byte; all other bytes keep flowing while the result waits.
//
module telemetry_frame_decoder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data,
    tdf_byte_if.sink                        frame_bytes,
    tdf_result_if.source                    results
);
    import tdf_pkg::*;

    logic [7:0]  magic_reg;
    logic [7:0]  version_reg;
    logic        accept;
    tdf_ctl_t    ctl;
    tdf_result_t frame_res;
    tdf_result_t res_reg;
    logic        res_valid_reg, res_valid_next;

    // Configuration registers; user must write only while idle, not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= '0;
            version_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAGIC:   magic_reg   <= cfg_data;
                REG_VERSION: version_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Hold input only if this byte may close a frame and the result slot is full.
    assign frame_bytes.ready = !(res_valid_reg && !results.ready && ctl.at_last);
    assign accept            = frame_bytes.valid && frame_bytes.ready;

    tdf_frame_ctl u_ctl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (frame_bytes.data_byte),
        .frame_start  (frame_bytes.frame_start),
        .magic_byte   (magic_reg),
        .version_byte (version_reg),
        .ctl          (ctl),
        .result       (frame_res)
    );

    // Result register
    assign res_valid_next = ctl.done || (res_valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done)
        begin
            res_reg <= frame_res;
        end
    end

    assign results.valid           = res_valid_reg;
    assign results.status          = res_reg.status;
    assign results.flags           = res_reg.flags;
    assign results.node_id         = res_reg.node_id;
    assign results.sequence_res    = res_reg.sequence_res;
    assign results.up_seconds      = res_reg.up_seconds;
    assign results.asset_temp      = res_reg.asset_temp;
    assign results.ambient_temp    = res_reg.ambient_temp;
    assign results.confidence      = res_reg.confidence;
    assign results.device_state    = res_reg.device_state;
    assign results.batt_millivolts = res_reg.batt_millivolts;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the telemetry frame decoder. Frames of 22 bytes are
// queued as byte requests. Some are well formed and some carry a bad header,
// a bad CRC, a cut-off tail or stray bytes. A local decoder predicts each
// frame result, and every result taken from the block is compared with it
// field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tdf_pkg::*;

    // Content patterns for frame bytes 3..19.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;
    localparam int FILL_EDGE   = 3;   // most negative / most positive temperatures

    localparam int FRAME_BYTES = 22;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } frame_byte_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    tdf_byte_if   byte_ch ();
    tdf_result_if result_ch ();

    telemetry_frame_decoder_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .frame_bytes (byte_ch),
        .results     (result_ch)
    );

    // Byte requests waiting to be offered, and decoded frames still owed
    // by the block.
    frame_byte_t byte_queue [$];
    tdf_result_t frame_expect [$];
    int          fail_count;

    // Local copy of the configuration registers.
    logic [7:0] magic_reg;
    logic [7:0] version_reg;

    // Local decoder state.
    logic [4:0]  frame_pos;
    logic [15:0] crc_acc;
    logic        hdr_err;
    logic [7:0]  field_buf [FIELD_COUNT];
    logic [7:0]  crc_lo;

    // Sender and receiver pacing.
    int          burst_left;
    int          gap_left;
    int          run_left;
    int          hold_left;
    int          cycle_count;
    bit          ready_level;
    bit          long_hold_done;
    tdf_result_t predicted;
    tdf_result_t want;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Frame decoding model
    // ------------------------------------------------------------------------

    // CRC-16/CCITT-FALSE, one byte, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // Consumes one accepted byte; returns 1 when it closes a frame, with the
    // decoded result in res.
    function automatic bit decode_byte(input frame_byte_t it, output tdf_result_t res);
        logic [4:0]  pos;
        logic [15:0] rx_crc;
        res = '0;
        if (it.frame_start)
        begin
            // A start flag always opens a new frame, even mid-frame.
            frame_pos = POS_MAGIC;
            crc_acc   = CRC_INIT;
            hdr_err   = 1'b0;
        end
        else if (frame_pos >= POS_IDLE)
            return 1'b0;                // stray byte while idle
        pos = frame_pos;

        if (pos < POS_CRC_LO)
            crc_acc = crc_step(crc_acc, it.data_byte);
        if (pos == POS_MAGIC && it.data_byte != magic_reg)
            hdr_err = 1'b1;
        if (pos == POS_VERSION && it.data_byte != version_reg)
            hdr_err = 1'b1;
        if (pos == POS_TYPE && it.data_byte != FRAME_TYPE)
            hdr_err = 1'b1;
        if (pos >= POS_FIELD0 && pos < POS_CRC_LO)
            field_buf[pos - POS_FIELD0] = it.data_byte;
        if (pos == POS_CRC_LO)
            crc_lo = it.data_byte;

        if (pos != POS_CRC_HI)
        begin
            frame_pos = pos + 5'd1;
            return 1'b0;
        end

        frame_pos = POS_IDLE;
        rx_crc    = {it.data_byte, crc_lo};
        // Header check wins over CRC check; fields stay zero on any error.
        if (hdr_err)
            res.status = STATUS_BAD_HDR;
        else if (rx_crc != crc_acc)
            res.status = STATUS_BAD_CRC;
        else
        begin
            res.status          = STATUS_OK;
            res.flags           = field_buf[0];
            res.node_id         = {field_buf[2], field_buf[1]};
            res.sequence_res    = {field_buf[4], field_buf[3]};
            res.up_seconds      = {field_buf[8], field_buf[7], field_buf[6], field_buf[5]};
            res.asset_temp      = {field_buf[10], field_buf[9]};
            res.ambient_temp    = {field_buf[12], field_buf[11]};
            res.confidence      = field_buf[13];
            res.device_state    = field_buf[14];
            res.batt_millivolts = {field_buf[16], field_buf[15]};
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Byte driver: bursts of random length with random gaps. A request stays
    // up until the block takes it; each taken byte goes through the model.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            byte_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (decode_byte(byte_queue.pop_front(), predicted))
                    frame_expect.push_back(predicted);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    // Half of the bursts run back to back with no gap at all.
                    gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end
            end

            if (byte_ch.valid && !byte_ch.ready)
            begin
                // Request not taken yet: hold it as it is.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                byte_ch.valid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                byte_ch.valid       <= 1'b1;
                byte_ch.data_byte   <= byte_queue[0].data_byte;
                byte_ch.frame_start <= byte_queue[0].frame_start;
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: alternating ready/stall runs, occasional long ready
    // stretches, and long hold-offs. The first hold-off is started while bytes
    // are on offer so the result register fills and input backs up.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            result_ch.ready <= 1'b0;
            run_left       = 0;
            hold_left      = 0;
            cycle_count    = 0;
            ready_level    = 1'b0;
            long_hold_done = 1'b0;
        end
        else
        begin
            cycle_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if ((!long_hold_done && cycle_count > 600 && byte_ch.valid) ||
                     $urandom_range(0, 3999) == 0)
            begin
                long_hold_done = 1'b1;
                hold_left      = $urandom_range(150, 300);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    ready_level = !ready_level;
                    if (!ready_level)
                        run_left = $urandom_range(1, 5);
                    else if ($urandom_range(0, 3) == 0)
                        run_left = $urandom_range(40, 120);
                    else
                        run_left = $urandom_range(1, 8);
                end
                run_left--;
                result_ch.ready <= ready_level;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid && result_ch.ready)
        begin
            if (frame_expect.size() == 0)
            begin
                $display("%0t: result with no frame pending, expected none, actual status %0d",
                         $time, result_ch.status);
                fail_count++;
            end
            else
            begin
                want = frame_expect.pop_front();
                check_field("status", 32'(want.status), 32'(result_ch.status));
                check_field("flags", 32'(want.flags), 32'(result_ch.flags));
                check_field("node_id", 32'(want.node_id), 32'(result_ch.node_id));
                check_field("sequence_res", 32'(want.sequence_res),
                            32'(result_ch.sequence_res));
                check_field("up_seconds", want.up_seconds, result_ch.up_seconds);
                check_field("asset_temp", 32'(want.asset_temp), 32'(result_ch.asset_temp));
                check_field("ambient_temp", 32'(want.ambient_temp),
                            32'(result_ch.ambient_temp));
                check_field("confidence", 32'(want.confidence), 32'(result_ch.confidence));
                check_field("device_state", 32'(want.device_state),
                            32'(result_ch.device_state));
                check_field("batt_millivolts", 32'(want.batt_millivolts),
                            32'(result_ch.batt_millivolts));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Queues the first cut bytes of a frame with the given header bytes. The
    // CRC is computed over bytes 0..19 and optionally broken by one bit flip.
    task automatic queue_frame(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input int fill,
                               input bit bad_crc, input int cut);
        logic [7:0]  frame [FRAME_BYTES];
        logic [15:0] crc;
        frame[0] = b0;
        frame[1] = b1;
        frame[2] = b2;
        for (int i = 3; i < 20; i++)
        begin
            case (fill)
                FILL_ZERO: frame[i] = 8'h00;
                FILL_ONES: frame[i] = 8'hFF;
                FILL_EDGE: frame[i] = (i % 2 == 0) ? 8'h55 : 8'hAA;
                default:   frame[i] = 8'($urandom);
            endcase
        end
        if (fill == FILL_EDGE)
        begin
            frame[12] = 8'h00;  // asset_temp = -32768
            frame[13] = 8'h80;
            frame[14] = 8'hFF;  // ambient_temp = 32767
            frame[15] = 8'h7F;
        end
        crc = CRC_INIT;
        for (int i = 0; i < 20; i++)
            crc = crc_step(crc, frame[i]);
        if (bad_crc)
            crc = crc ^ (16'd1 << $urandom_range(0, 15));
        frame[20] = crc[7:0];
        frame[21] = crc[15:8];
        for (int i = 0; i < cut; i++)
            byte_queue.push_back({frame[i], i == 0});
    endtask

    task automatic queue_good_frame(input int fill);
        queue_frame(magic_reg, version_reg, FRAME_TYPE, fill, 1'b0, FRAME_BYTES);
    endtask

    // Bytes without a start flag: dropped when idle, frame bytes otherwise.
    task automatic queue_noise(input int count);
        repeat (count)
            byte_queue.push_back({8'($urandom), 1'b0});
    endtask

    // Mostly valid frames with random content; the rest break the header or
    // CRC, get cut short (so the next start flag restarts mid-frame) or are
    // stray bytes. A good frame closes the batch so the block ends up idle.
    task automatic queue_random_frames(input int count);
        int         sel;
        int         fill;
        int         which;
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] h2;
        repeat (count)
        begin
            sel  = $urandom_range(0, 99);
            fill = ($urandom_range(0, 9) == 0) ? $urandom_range(FILL_ZERO, FILL_EDGE)
                                               : FILL_RANDOM;
            if (sel < 62)
                queue_good_frame(fill);
            else if (sel < 72)
                queue_frame(magic_reg, version_reg, FRAME_TYPE, fill, 1'b1, FRAME_BYTES);
            else if (sel < 84)
            begin
                h0    = magic_reg;
                h1    = version_reg;
                h2    = FRAME_TYPE;
                which = $urandom_range(0, 2);
                if (which == 0)
                    h0 = h0 ^ 8'($urandom_range(1, 255));
                else if (which == 1)
                    h1 = h1 ^ 8'($urandom_range(1, 255));
                else
                    h2 = h2 ^ 8'($urandom_range(1, 255));
                queue_frame(h0, h1, h2, fill, 1'($urandom_range(0, 1)), FRAME_BYTES);
            end
            else if (sel < 93)
                queue_frame(magic_reg, version_reg, FRAME_TYPE, fill, 1'b0,
                            $urandom_range(1, FRAME_BYTES - 1));
            else
                queue_noise($urandom_range(1, 4));
        end
        queue_good_frame(FILL_RANDOM);
    endtask

    // Wait until every byte is taken and every frame result is back, then
    // give the block a few cycles more in case a cut-off frame is in flight.
    task automatic wait_idle();
        while (byte_queue.size() != 0 || frame_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAGIC)
            magic_reg = value;
        else
            version_reg = value;
    endtask

    task automatic set_header(input logic [7:0] magic, input logic [7:0] version);
        write_reg(REG_MAGIC, magic);
        write_reg(REG_VERSION, version);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_MAGIC;
        cfg_data            = 8'h00;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'h00;
        byte_ch.frame_start = 1'b0;
        result_ch.ready     = 1'b0;
        fail_count          = 0;
        magic_reg           = 8'h00;
        version_reg         = 8'h00;
        frame_pos           = POS_IDLE;
        crc_acc             = CRC_INIT;
        hdr_err             = 1'b0;
        crc_lo              = 8'h00;
        for (int i = 0; i < FIELD_COUNT; i++)
            field_buf[i] = 8'h00;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset header values (both zero).
        queue_noise(3);                               // idle bytes, dropped
        queue_good_frame(FILL_ZERO);
        queue_good_frame(FILL_ONES);
        queue_good_frame(FILL_EDGE);
        queue_frame(8'h01, 8'h00, FRAME_TYPE, FILL_RANDOM, 1'b0, FRAME_BYTES); // bad magic
        queue_frame(8'h00, 8'h80, FRAME_TYPE, FILL_RANDOM, 1'b0, FRAME_BYTES); // bad version
        queue_frame(8'h00, 8'h00, 8'hFE, FILL_RANDOM, 1'b0, FRAME_BYTES);      // bad type
        queue_frame(8'h00, 8'h00, FRAME_TYPE, FILL_RANDOM, 1'b1, FRAME_BYTES); // bad CRC
        queue_frame(8'hFF, 8'h00, FRAME_TYPE, FILL_RANDOM, 1'b1, FRAME_BYTES); // both bad
        queue_frame(8'h00, 8'h00, FRAME_TYPE, FILL_RANDOM, 1'b0, 10);  // cut, then restart
        queue_frame(8'h00, 8'h00, FRAME_TYPE, FILL_RANDOM, 1'b0, 21);  // cut before last
        queue_good_frame(FILL_RANDOM);
        queue_noise(2);
        byte_queue.push_back({8'hFF, 1'b0});
        wait_idle();

        // Top extreme of both registers.
        set_header(8'hFF, 8'hFF);
        queue_good_frame(FILL_EDGE);
        queue_frame(8'hFF, 8'hFE, FRAME_TYPE, FILL_RANDOM, 1'b0, FRAME_BYTES);
        queue_random_frames(7);
        wait_idle();

        set_header(8'($urandom), 8'($urandom));
        queue_random_frames(7);
        wait_idle();

        set_header(8'h5A, 8'h00);
        queue_random_frames(7);
        wait_idle();

        set_header(8'($urandom), 8'($urandom));
        queue_random_frames(7);
        wait_idle();

        // Let any stray result show up before the verdict.
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Run limit: far above the slowest legal run (about 900 bytes with gaps,
    // stalled results and long hold-offs).
    initial
    begin
        #400000;
        $display("tb_top failed");
        $finish;
    end

endmodule
